// ===== rtl/scan_sector_minimum_core_defines.svh =====
// Assertion macros used by the checker file of the scan sector minimum core.
`ifndef SCAN_SECTOR_MINIMUM_CORE_DEFINES_SVH
`define SCAN_SECTOR_MINIMUM_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SSM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("scan sector minimum core check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("scan sector minimum core check failed");

`endif

// ===== rtl/ssm_pkg.sv =====
// Package with the types, widths and constants of the scan sector minimum core.
package ssm_pkg;

  localparam int DIRECTIONS  = 8;
  localparam int MAX_SAMPLES = 4096;

  localparam int RANGE_W    = 16;
  localparam int SECTOR_W   = 6;
  localparam int LEN_W      = 13;
  localparam int IDX_W      = 12;
  localparam int SW_W       = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int DIR_W      = (DIRECTIONS > 1) ? $clog2(DIRECTIONS) : 1;
  localparam int MOD_CNT_W  = $clog2(IDX_W + 1);

  localparam logic [LEN_W-1:0] SCAN_LENGTH_RST  = 13'd360;
  localparam logic [IDX_W-1:0] ZERO_INDEX_RST   = 12'd0;
  localparam logic [SW_W-1:0]  SECTOR_WIDTH_RST = 10'd45;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLED      = 2'd0,
    REG_SCAN_LENGTH  = 2'd1,
    REG_ZERO_INDEX   = 2'd2,
    REG_SECTOR_WIDTH = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    MOD_ZERO_INDEX = 2'd0,
    MOD_WIDTH      = 2'd1,
    MOD_HALF_WIDTH = 2'd2
  } mod_sel_e;

  typedef struct packed {
    logic     mod_start;
    mod_sel_e mod_sel;
    logic     cap_zero;
    logic     cap_width;
    logic     cap_half;
    logic     starts_init;
    logic     starts_step;
    logic     take;
    logic     emit_load;
  } ssm_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic starts_last;
    logic emit_last;
    logic out_free;
    logic enabled;
  } ssm_stat_t;

endpackage

// ===== rtl/scan_sector_minimum_core.sv =====
// Top level of the scan sector minimum core: per-sector minimum range of one lidar scan.
//
//   channel   direction   handshake            word
//   cfg       in          cfg_we_i             cfg_index_i, cfg_data_i
//   in        in          in_valid_i/stall_o   range_mm_i, scan_end_i
//   out       out         out_valid_o/stall_i  sector_index_o, sector_min_o, last_sector_o
//
// Samples are accepted back to back while the core runs and no register is being written.
// After reset and after every register write the core rebuilds its sector start table
// (three modulo reductions, then one sector per cycle)
// and stalls the input meanwhile.
// A scan end with enabled set emits DIRECTIONS words, one per cycle from the output
// register, during which the input stalls; an output stall holds the word and the emission.

module scan_sector_minimum_core
  import ssm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [RANGE_W-1:0]    range_mm_i,
  input  logic                  scan_end_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SECTOR_W-1:0]   sector_index_o,
  output logic [RANGE_W-1:0]    sector_min_o,
  output logic                  last_sector_o
);

  ssm_cmd_t  cmd;
  ssm_stat_t stat;

  ssm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .in_valid_i (in_valid_i),
    .scan_end_i (scan_end_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  ssm_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .range_mm_i     (range_mm_i),
    .scan_end_i     (scan_end_i),
    .out_stall_i    (out_stall_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .sector_index_o (sector_index_o),
    .sector_min_o   (sector_min_o),
    .last_sector_o  (last_sector_o)
  );

endmodule

// ===== rtl/ssm_mod_unit.sv =====
// Restoring modulo unit that reduces an index or a width by the scan length, one bit per cycle.
module ssm_mod_unit
  import ssm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [IDX_W-1:0] dividend_i,
  input  logic [LEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [IDX_W-1:0] rem_o
);

  logic [MOD_CNT_W-1:0] cnt_q;
  logic [IDX_W-1:0]     x_q;
  logic [IDX_W-1:0]     rem_q;
  logic [LEN_W-1:0]     trial;
  logic [IDX_W-1:0]     rem_d;

  always_comb begin
    trial = {rem_q, x_q[IDX_W-1]};
    if (trial >= divisor_i) begin
      rem_d = IDX_W'(trial - divisor_i);
    end else begin
      rem_d = trial[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= MOD_CNT_W'(IDX_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - MOD_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= dividend_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      x_q   <= {x_q[IDX_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = (cnt_q == '0);
  assign rem_o  = rem_q;

endmodule

// ===== rtl/ssm_datapath.sv =====
// Datapath: configuration registers, sector start table, per-sector minima and output register.
module ssm_datapath
  import ssm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [RANGE_W-1:0]    range_mm_i,
  input  logic                  scan_end_i,
  input  logic                  out_stall_i,
  input  ssm_cmd_t              cmd_i,
  output ssm_stat_t             stat_o,
  output logic                  out_valid_o,
  output logic [SECTOR_W-1:0]   sector_index_o,
  output logic [RANGE_W-1:0]    sector_min_o,
  output logic                  last_sector_o
);

  logic             enabled_q;
  logic [LEN_W-1:0] scan_length_q;
  logic [IDX_W-1:0] zero_index_q;
  logic [SW_W-1:0]  sector_width_q;

  logic [LEN_W-1:0] len_eff;
  logic [SW_W-1:0]  w_eff;

  logic [IDX_W-1:0] mod_x;
  logic             mod_done;
  logic [IDX_W-1:0] mod_rem;

  logic [IDX_W-1:0] zm_q;
  logic [IDX_W-1:0] wm_q;
  logic [IDX_W-1:0] hm_q;

  logic [IDX_W-1:0] a_q;
  logic [DIR_W-1:0] k_q;
  logic [IDX_W-1:0] start_q [DIRECTIONS];
  logic [LEN_W-1:0] start_sum;
  logic [LEN_W-1:0] a_sum;

  logic [IDX_W-1:0] count_q;
  logic [IDX_W-1:0] count_d;
  logic [LEN_W-1:0] count_inc;
  logic             idx_ok;

  logic [RANGE_W-1:0] min_q [DIRECTIONS];
  logic [LEN_W-1:0]   off_w [DIRECTIONS];
  logic [DIRECTIONS-1:0] lane_load;
  logic [DIRECTIONS-1:0] lane_upd;

  logic [DIR_W-1:0]    e_q;
  logic                emit_last;
  logic                out_free;
  logic                out_valid_q;
  logic [SECTOR_W-1:0] sector_index_q;
  logic [RANGE_W-1:0]  sector_min_q;
  logic                last_sector_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q      <= 1'b0;
      scan_length_q  <= SCAN_LENGTH_RST;
      zero_index_q   <= ZERO_INDEX_RST;
      sector_width_q <= SECTOR_WIDTH_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_ENABLED:      enabled_q      <= cfg_data_i[0];
        REG_SCAN_LENGTH:  scan_length_q  <= cfg_data_i[LEN_W-1:0];
        REG_ZERO_INDEX:   zero_index_q   <= cfg_data_i[IDX_W-1:0];
        REG_SECTOR_WIDTH: sector_width_q <= cfg_data_i[SW_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (scan_length_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (scan_length_q > LEN_W'(MAX_SAMPLES)) begin
      len_eff = LEN_W'(MAX_SAMPLES);
    end else begin
      len_eff = scan_length_q;
    end
    w_eff = (sector_width_q == '0) ? SW_W'(1) : sector_width_q;
  end

  always_comb begin
    case (cmd_i.mod_sel)
      MOD_ZERO_INDEX: mod_x = zero_index_q;
      MOD_WIDTH:      mod_x = IDX_W'(w_eff);
      MOD_HALF_WIDTH: mod_x = IDX_W'(w_eff >> 1);
      default:        mod_x = zero_index_q;
    endcase
  end

  ssm_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (mod_x),
    .divisor_i  (len_eff),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_zero) begin
      zm_q <= mod_rem;
    end
    if (cmd_i.cap_width) begin
      wm_q <= mod_rem;
    end
    if (cmd_i.cap_half) begin
      hm_q <= mod_rem;
    end
  end

  // Sector m starts half a sector before zero_index + m * sector_width, modulo the length.
  always_comb begin
    start_sum = {1'b0, a_q} - {1'b0, hm_q};
    if (a_q < hm_q) begin
      start_sum = start_sum + len_eff;
    end
    a_sum = {1'b0, a_q} + {1'b0, wm_q};
    if (a_sum >= len_eff) begin
      a_sum = a_sum - len_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.starts_init) begin
      k_q <= '0;
    end else if (cmd_i.starts_step) begin
      k_q <= k_q + DIR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.starts_init) begin
      a_q <= zm_q;
    end else if (cmd_i.starts_step) begin
      a_q          <= a_sum[IDX_W-1:0];
      start_q[k_q] <= start_sum[IDX_W-1:0];
    end
  end

  always_comb begin
    idx_ok    = ({1'b0, count_q} < len_eff);
    count_inc = {1'b0, count_q} + LEN_W'(1);
    if (scan_end_i || !idx_ok || (count_inc >= len_eff)) begin
      count_d = '0;
    end else begin
      count_d = count_inc[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.take) begin
      count_q <= count_d;
    end
  end

  always_comb begin
    for (int g = 0; g < DIRECTIONS; g++) begin
      off_w[g] = {1'b0, count_q} - {1'b0, start_q[g]};
      if (count_q < start_q[g]) begin
        off_w[g] = off_w[g] + len_eff;
      end
      lane_load[g] = cmd_i.take && idx_ok && (off_w[g] == '0);
      lane_upd[g]  = cmd_i.take && idx_ok && (off_w[g] != '0) &&
                     (off_w[g] < LEN_W'(w_eff)) && (range_mm_i != '0) &&
                     (range_mm_i < min_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < DIRECTIONS; g++) begin
      if (lane_load[g] || lane_upd[g]) begin
        min_q[g] <= range_mm_i;
      end
    end
  end

  assign emit_last = (e_q == DIR_W'(DIRECTIONS - 1));
  assign out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      e_q         <= emit_last ? '0 : e_q + DIR_W'(1);
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      sector_index_q <= SECTOR_W'(e_q);
      sector_min_q   <= min_q[e_q];
      last_sector_q  <= emit_last;
    end
  end

  assign stat_o.mod_done    = mod_done;
  assign stat_o.starts_last = (k_q == DIR_W'(DIRECTIONS - 1));
  assign stat_o.emit_last   = emit_last;
  assign stat_o.out_free    = out_free;
  assign stat_o.enabled     = enabled_q;

  assign out_valid_o    = out_valid_q;
  assign sector_index_o = sector_index_q;
  assign sector_min_o   = sector_min_q;
  assign last_sector_o  = last_sector_q;

endmodule

// ===== rtl/ssm_ctrl.sv =====
// Controller state machine: sector start setup, sample intake and result emission.
module ssm_ctrl
  import ssm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      in_valid_i,
  input  logic      scan_end_i,
  input  ssm_stat_t stat_i,
  output ssm_cmd_t  cmd_o,
  output logic      in_stall_o
);

  typedef enum logic [3:0] {
    ST_ZM_GO,
    ST_ZM_WAIT,
    ST_W_GO,
    ST_W_WAIT,
    ST_H_GO,
    ST_H_WAIT,
    ST_START_INIT,
    ST_START_STEP,
    ST_RUN,
    ST_EMIT
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   redo_q;
  logic   redo_d;

  always_comb begin
    state_d       = state_q;
    redo_d        = redo_q;
    cmd_o         = '0;
    cmd_o.mod_sel = MOD_ZERO_INDEX;
    unique case (state_q)
      ST_ZM_GO: begin
        cmd_o.mod_start = 1'b1;
        state_d         = ST_ZM_WAIT;
      end
      ST_ZM_WAIT: begin
        if (stat_i.mod_done) begin
          cmd_o.cap_zero = 1'b1;
          state_d        = ST_W_GO;
        end
      end
      ST_W_GO: begin
        cmd_o.mod_start = 1'b1;
        cmd_o.mod_sel   = MOD_WIDTH;
        state_d         = ST_W_WAIT;
      end
      ST_W_WAIT: begin
        if (stat_i.mod_done) begin
          cmd_o.cap_width = 1'b1;
          state_d         = ST_H_GO;
        end
      end
      ST_H_GO: begin
        cmd_o.mod_start = 1'b1;
        cmd_o.mod_sel   = MOD_HALF_WIDTH;
        state_d         = ST_H_WAIT;
      end
      ST_H_WAIT: begin
        if (stat_i.mod_done) begin
          cmd_o.cap_half = 1'b1;
          state_d        = ST_START_INIT;
        end
      end
      ST_START_INIT: begin
        cmd_o.starts_init = 1'b1;
        state_d           = ST_START_STEP;
      end
      ST_START_STEP: begin
        cmd_o.starts_step = 1'b1;
        if (stat_i.starts_last) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.take = in_valid_i && !cfg_we_i;
        if (cmd_o.take && scan_end_i && stat_i.enabled) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit_load = stat_i.out_free;
        if (cfg_we_i) begin
          redo_d = 1'b1;
        end
        if (stat_i.out_free && stat_i.emit_last) begin
          state_d = (redo_q || cfg_we_i) ? ST_ZM_GO : ST_RUN;
          redo_d  = 1'b0;
        end
      end
      default: begin
        state_d = ST_ZM_GO;
      end
    endcase
    // A register write invalidates the start table, so setup runs again.
    if (cfg_we_i && (state_q != ST_EMIT)) begin
      state_d = ST_ZM_GO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ZM_GO;
      redo_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      redo_q  <= redo_d;
    end
  end

  assign in_stall_o = (state_q != ST_RUN) || cfg_we_i;

endmodule

// ===== rtl/ssm_checker.sv =====
// Port-level checker for the scan sector minimum core and its bind to the top level.
`include "scan_sector_minimum_core_defines.svh"

module ssm_checker
  import ssm_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_i,
  input logic                out_valid_i,
  input logic                out_stall_i,
  input logic [SECTOR_W-1:0] sector_index_i,
  input logic [RANGE_W-1:0]  sector_min_i,
  input logic                last_sector_i
);

  `SSM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i,
                   out_valid_i && $stable(sector_index_i) && $stable(sector_min_i))
  `SSM_ASSERT_NEXT(a_index_steps, clk_i, rst_ni, out_valid_i && !out_stall_i && !last_sector_i,
                   out_valid_i && (sector_index_i == $past(sector_index_i) + 6'd1))
  `SSM_ASSERT_NOW(a_last_index, clk_i, rst_ni, out_valid_i && last_sector_i,
                  sector_index_i == SECTOR_W'(DIRECTIONS - 1))
  `SSM_ASSERT_NOW(a_input_held, clk_i, rst_ni, out_valid_i && !last_sector_i, in_stall_i)

endmodule

bind scan_sector_minimum_core ssm_checker u_ssm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_i     (in_stall_o),
  .out_valid_i    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .sector_index_i (sector_index_o),
  .sector_min_i   (sector_min_o),
  .last_sector_i  (last_sector_o)
);

// ===== tb/sv/tb_scan_sector_minimum_core.sv =====
// Self-checking testbench for the scan sector minimum core with a per-sector minimum predictor.
`timescale 1ns / 1ps

module tb_scan_sector_minimum_core;
  import ssm_pkg::*;

  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic [RANGE_W-1:0]  minimum;
    logic                last_flag;
  } sector_word_t;

  class sector_scoreboard;
    logic                  enabled_q;
    logic [LEN_W-1:0]      scan_length_q;
    logic [IDX_W-1:0]      zero_index_q;
    logic [SW_W-1:0]       sector_width_q;
    logic [IDX_W-1:0]      sample_idx;
    logic [RANGE_W-1:0]    minima [DIRECTIONS];
    sector_word_t          expected_words [$];
    int                    errors;

    function new();
      enabled_q      = 1'b0;
      scan_length_q  = SCAN_LENGTH_RST;
      zero_index_q   = ZERO_INDEX_RST;
      sector_width_q = SECTOR_WIDTH_RST;
      sample_idx     = '0;
      errors         = 0;
      foreach (minima[m]) minima[m] = '0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ENABLED:      enabled_q = data[0];
        REG_SCAN_LENGTH:  scan_length_q = data[LEN_W-1:0];
        REG_ZERO_INDEX:   zero_index_q = data[IDX_W-1:0];
        REG_SECTOR_WIDTH: sector_width_q = data[SW_W-1:0];
        default: ;
      endcase
    endfunction

    // Updates the sector minima for one accepted word and queues the emission on an enabled scan end.
    function void note_sample(logic [RANGE_W-1:0] range_mm, logic scan_end);
      int unsigned len, width, zm, half, ahead, start, offset, idx;
      sector_word_t word;
      len = (scan_length_q == 0) ? 1 : scan_length_q;
      if (len > MAX_SAMPLES) len = MAX_SAMPLES;
      width = (sector_width_q == 0) ? 1 : sector_width_q;
      idx = sample_idx;
      if (idx < len) begin
        zm = zero_index_q % len;
        half = (width / 2) % len;
        for (int m = 0; m < DIRECTIONS; m++) begin
          ahead = (m * width + zm) % len;
          start = (ahead + len - half) % len;
          offset = (idx + len - start) % len;
          if (offset == 0) begin
            minima[m] = range_mm;
          end else if (offset < width) begin
            if (range_mm != 0 && range_mm < minima[m]) minima[m] = range_mm;
          end
        end
        sample_idx = (idx + 1 >= len) ? '0 : IDX_W'(idx + 1);
      end else begin
        sample_idx = '0;
      end
      if (scan_end) begin
        sample_idx = '0;
        if (enabled_q) begin
          for (int m = 0; m < DIRECTIONS; m++) begin
            word.sector = SECTOR_W'(m);
            word.minimum = minima[m];
            word.last_flag = (m == DIRECTIONS - 1);
            expected_words.push_back(word);
          end
        end
      end
    endfunction

    function void check_word(logic [SECTOR_W-1:0] sector, logic [RANGE_W-1:0] minimum,
                             logic last_flag);
      sector_word_t exp_word;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected sector word, expected none, got sector %0d min %0d last %0b",
                 $time, sector, minimum, last_flag);
        return;
      end
      exp_word = expected_words.pop_front();
      if (sector !== exp_word.sector) begin
        errors++;
        $display("%0t: sector_index mismatch, expected %0d, got %0d",
                 $time, exp_word.sector, sector);
      end
      if (minimum !== exp_word.minimum) begin
        errors++;
        $display("%0t: sector_min mismatch for sector %0d, expected %0d, got %0d",
                 $time, exp_word.sector, exp_word.minimum, minimum);
      end
      if (last_flag !== exp_word.last_flag) begin
        errors++;
        $display("%0t: last_sector mismatch for sector %0d, expected %0b, got %0b",
                 $time, exp_word.sector, exp_word.last_flag, last_flag);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [RANGE_W-1:0]    range_mm_i = '0;
  logic                  scan_end_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [SECTOR_W-1:0]   sector_index_o;
  logic [RANGE_W-1:0]    sector_min_o;
  logic                  last_sector_o;

  sector_scoreboard sb = new();
  int  sent = 0;
  bit  calm = 1'b0;

  scan_sector_minimum_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .range_mm_i     (range_mm_i),
    .scan_end_i     (scan_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sector_index_o (sector_index_o),
    .sector_min_o   (sector_min_o),
    .last_sector_o  (last_sector_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 24);
  end

  // Outputs only move at the rising edge, so a word seen at the falling edge is what is taken.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_word(sector_index_o, sector_min_o, last_sector_o);
    end
  end

  function automatic logic [RANGE_W-1:0] pick_range();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2, 3: return RANGE_W'($urandom_range(1, 2000));
      default: return RANGE_W'($urandom());
    endcase
  endfunction

  task automatic send_sample(input logic [RANGE_W-1:0] range_mm, input logic scan_end);
    calm = (sent >= 120 && sent < 180);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    range_mm_i <= range_mm;
    scan_end_i <= scan_end;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    sb.note_sample(range_mm, scan_end);
    sent++;
  endtask

  // Waits until every expected word has arrived and the core has worked off trailing samples.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [CFG_DATA_W-1:0] en_d, len_d, zi_d, w_d);
    logic [CFG_DATA_W-1:0] vals [4];
    vals = '{en_d, len_d, zi_d, w_d};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= reg_idx_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.write_reg(reg_idx_e'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    #2_000_000;
    $display("scan_sector_minimum_core verification failed");
    $finish;
  end

  initial begin
    logic [RANGE_W-1:0]    first_scan [8];
    logic [CFG_DATA_W-1:0] en_d, len_d, zi_d, w_d;
    int                    n, eff_len;
    first_scan = '{16'hFFFF, 16'd0, 16'd1, 16'hAAAA, 16'h5555, 16'd0, 16'd300, 16'd200};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A full short scan first, so that every sector minimum is loaded before any is reported.
    write_config(13'd1, 13'd8, 13'd0, 13'd2);
    for (int i = 0; i < 8; i++) send_sample(first_scan[i], i == 7);

    // Samples past the scan length wrap around into a new pass.
    settle();
    write_config(13'd1, 13'd3, 13'd1, 13'd1);
    for (int i = 0; i < 5; i++) send_sample(pick_range(), i == 4);

    // Scan length lowered below the current sample count mid-scan.
    settle();
    write_config(13'd1, 13'd40, 13'd5, 13'd4);
    for (int i = 0; i < 6; i++) send_sample(pick_range(), 1'b0);
    settle();
    write_config(13'd1, 13'd4, 13'd5, 13'd4);
    for (int i = 0; i < 2; i++) send_sample(pick_range(), i == 1);

    // Zero length and zero width, then everything saturated, then a disabled scan end.
    settle();
    write_config(13'd1, 13'd0, 13'd0, 13'd0);
    for (int i = 0; i < 2; i++) send_sample(pick_range(), i == 1);
    settle();
    write_config(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
    for (int i = 0; i < 2; i++) send_sample(pick_range(), i == 1);
    settle();
    write_config(13'h1FFE, 13'd16, 13'd0, 13'd2);
    send_sample(pick_range(), 1'b1);

    while (sent < 230) begin
      settle();
      en_d = {12'($urandom()), 1'($urandom_range(9) != 0)};
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: len_d = 13'd0;
          1: len_d = 13'd4096;
          2: len_d = 13'h1FFF;
          default: len_d = 13'($urandom_range(4097, 8191));
        endcase
        zi_d = 13'($urandom_range(8191));
        w_d = 13'($urandom_range(8191));
      end else begin
        len_d = 13'($urandom_range(1, 48));
        zi_d = {1'($urandom()),
                ($urandom_range(9) == 0) ? 12'hFFF : 12'($urandom_range(63))};
        case ($urandom_range(11))
          0: w_d = {3'($urandom()), 10'd0};
          1: w_d = {3'($urandom()), 10'd512};
          2: w_d = {3'($urandom()), 10'd1023};
          default: w_d = {3'($urandom()), 10'($urandom_range(1, 12))};
        endcase
      end
      write_config(en_d, len_d, zi_d, w_d);
      eff_len = (len_d == 0) ? 1 : ((len_d > MAX_SAMPLES) ? MAX_SAMPLES : len_d);

      repeat ($urandom_range(1, 3)) begin
        if (eff_len > 64) begin
          n = $urandom_range(1, 20);
          for (int i = 0; i < n; i++) begin
            send_sample(pick_range(), (i == n - 1) && ($urandom_range(9) != 0));
          end
        end else if ($urandom_range(4) != 0) begin
          for (int i = 0; i < eff_len; i++) send_sample(pick_range(), i == eff_len - 1);
        end else begin
          n = $urandom_range(1, 2 * eff_len);
          for (int i = 0; i < n; i++) send_sample(pick_range(), $urandom_range(7) == 0);
        end
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("scan_sector_minimum_core verification clean");
    end else begin
      $display("scan_sector_minimum_core verification failed");
    end
    $finish;
  end

endmodule

// ===== scan_sector_minimum_core.f =====
+incdir+rtl
rtl/ssm_pkg.sv
rtl/ssm_mod_unit.sv
rtl/ssm_datapath.sv
rtl/ssm_ctrl.sv
rtl/scan_sector_minimum_core.sv
rtl/ssm_checker.sv
tb/sv/tb_scan_sector_minimum_core.sv
